// ===== hdl/peeu_pkg.sv =====
// ============================================================================
// peeu_pkg
// Shared types and constants for the command-unlocked cartridge EEPROM.
// ============================================================================
`default_nettype none

package peeu_pkg;

    // bus access codes
    typedef enum logic [1:0] {
        OP_READ_LONG  = 2'd0,
        OP_READ_WORD  = 2'd1,
        OP_WRITE_WORD = 2'd2,
        OP_WRITE_LONG = 2'd3
    } op_t;

    // command mode
    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_PROD_ID  = 2'd1,
        MODE_WRITE_EN = 2'd2
    } mode_t;

    // unlock sequence phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ONE  = 2'd1,
        PH_TWO  = 2'd2
    } phase_t;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_ACCESS,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic reduce;
        logic access;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic is_read;
        logic out_free;
    } status_t;

    // slots addressed by bus address bits 18:2
    localparam int SLOT_BITS  = 17;
    localparam int FULL_SLOTS = 131072;

    localparam logic [23:0] BASE_ADDR     = 24'h800000;
    localparam logic [23:0] ID_ADDR_MFR   = 24'h800000;
    localparam logic [23:0] ID_ADDR_DEV   = 24'h800004;
    localparam logic [23:0] UNLOCK_ADDR_A = 24'(BASE_ADDR + 24'(4 * 24'h5555));
    localparam logic [23:0] UNLOCK_ADDR_B = 24'(BASE_ADDR + 24'(4 * 24'h2AAA));
    localparam logic [23:0] LONG_MASK     = 24'hFFFFFC;

    localparam logic [7:0]  ID_MFR        = 8'h1F;
    localparam logic [7:0]  ID_DEV        = 8'hD5;
    localparam logic [7:0]  ERASED_BYTE   = 8'hFF;

    localparam logic [15:0] UNLOCK_DATA_1 = 16'h00AA;
    localparam logic [15:0] UNLOCK_DATA_2 = 16'h0055;
    localparam logic [15:0] CMD_PROD_ID   = 16'h0090;
    localparam logic [15:0] CMD_WRITE_EN  = 16'h00A0;

endpackage

`default_nettype wire

// ===== hdl/parallel_eeprom_command_unlock.sv =====
// ============================================================================
// parallel_eeprom_command_unlock
// Cartridge EEPROM with one byte per bus longword, a product id mode and a
// three-write unlock sequence that enables byte writes.
// ============================================================================
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, opcode, bus_address,     | input
//          | write_value                                  |
//  out     | out_valid, out_ready, read_value             | output
//
//  One transaction at a time: capture, then R compare-and-subtract steps that
//  fold the slot into STORE_DEPTH (0 at the default depth, up to 7 at 1024),
//  then the store access; a read then waits for the output register.
//  After reset a clearing pass writes 0xFF to every entry with in_ready low.
//  Writes give no result; a held result does not block writes.
//
`default_nettype none

module parallel_eeprom_command_unlock #(
    parameter int STORE_DEPTH = 131072
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  opcode,
    input  wire  [23:0] bus_address,
    input  wire  [31:0] write_value,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [31:0] read_value
);

    peeu_pkg::cmd_t     cmd;
    peeu_pkg::status_t  status;

    // sequencer
    peeu_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // store and command state
    peeu_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .opcode      (opcode),
        .bus_address (bus_address),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value)
    );

endmodule

`default_nettype wire

// ===== hdl/peeu_ctrl.sv =====
// ============================================================================
// peeu_ctrl
// Sequencer: clearing pass after reset, then capture, slot reduction,
// store access and result handoff for one bus transaction at a time.
// ============================================================================
`default_nettype none

module peeu_ctrl #(
    parameter int STORE_DEPTH = 131072
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  peeu_pkg::status_t   status,
    output peeu_pkg::cmd_t      cmd
);

    // compare-and-subtract steps that bring a 17-bit slot below the depth
    localparam int RED_STEPS =
        $clog2((peeu_pkg::FULL_SLOTS + STORE_DEPTH - 1) / STORE_DEPTH);
    localparam int STEP_W    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam int LAST_STEP = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;

    peeu_pkg::state_t   state_reg;
    peeu_pkg::state_t   state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= peeu_pkg::ST_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            peeu_pkg::ST_CLEAR:
            begin
                if (status.clear_done)
                    state_next = peeu_pkg::ST_IDLE;
            end
            peeu_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                    state_next = (RED_STEPS > 0) ? peeu_pkg::ST_REDUCE
                                                 : peeu_pkg::ST_ACCESS;
            end
            peeu_pkg::ST_REDUCE:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(LAST_STEP))
                    state_next = peeu_pkg::ST_ACCESS;
            end
            peeu_pkg::ST_ACCESS:
            begin
                state_next = status.is_read ? peeu_pkg::ST_RESULT : peeu_pkg::ST_IDLE;
            end
            peeu_pkg::ST_RESULT:
            begin
                if (status.out_free)
                    state_next = peeu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = peeu_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            peeu_pkg::ST_CLEAR:  cmd.clear_step = 1'b1;
            peeu_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            peeu_pkg::ST_REDUCE: cmd.reduce = 1'b1;
            peeu_pkg::ST_ACCESS: cmd.access = 1'b1;
            peeu_pkg::ST_RESULT: cmd.out_load = status.out_free;
            default:             cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/peeu_datapath.sv =====
// ============================================================================
// peeu_datapath
// Byte store, command mode and unlock phase, slot reduction and the
// registered read result.
// ============================================================================
`default_nettype none

module peeu_datapath #(
    parameter int STORE_DEPTH = 131072
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  peeu_pkg::cmd_t      cmd,
    output peeu_pkg::status_t   status,
    input  wire  [1:0]          opcode,
    input  wire  [23:0]         bus_address,
    input  wire  [31:0]         write_value,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [31:0]         read_value
);

    localparam int SLOT_W    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int RED_STEPS =
        $clog2((peeu_pkg::FULL_SLOTS + STORE_DEPTH - 1) / STORE_DEPTH);
    localparam int DIV_SHIFT = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
    localparam logic [peeu_pkg::SLOT_BITS-1:0] DIV_INIT =
        peeu_pkg::SLOT_BITS'(STORE_DEPTH << DIV_SHIFT);

    // byte store
    logic [7:0]                     mem [STORE_DEPTH];

    // captured transaction
    peeu_pkg::op_t                  op_reg;
    logic [23:0]                    addr_reg;
    logic [15:0]                    data_reg;
    logic [peeu_pkg::SLOT_BITS-1:0] red_reg;
    logic [peeu_pkg::SLOT_BITS-1:0] div_reg;

    // read side
    logic [7:0]                     rd_data_reg;
    logic                           pid_reg;
    logic [7:0]                     id_reg;

    // control state
    peeu_pkg::mode_t                mode_reg;
    peeu_pkg::mode_t                mode_next;
    peeu_pkg::phase_t               phase_reg;
    peeu_pkg::phase_t               phase_next;
    logic [SLOT_W-1:0]              clr_cnt_reg;
    logic                           out_valid_reg;
    logic [31:0]                    out_data_reg;

    logic                           is_read;
    logic                           is_long_wr;
    logic [23:0]                    eff_addr;
    logic                           wr_taken;
    logic                           store_wr;
    logic                           hit_a;
    logic                           hit_b;
    logic [SLOT_W-1:0]              slot;
    logic [SLOT_W-1:0]              mem_waddr;
    logic [7:0]                     mem_wdata;
    logic                           mem_we;
    logic [7:0]                     id_byte;
    logic [7:0]                     res_byte;
    logic [31:0]                    res_value;

    // decode of the captured transaction
    assign is_read    = (op_reg == peeu_pkg::OP_READ_LONG) ||
                        (op_reg == peeu_pkg::OP_READ_WORD);
    assign is_long_wr = (op_reg == peeu_pkg::OP_WRITE_LONG);
    assign eff_addr   = is_long_wr ? (addr_reg & peeu_pkg::LONG_MASK) : addr_reg;
    assign wr_taken   = !is_read && (eff_addr[1:0] != 2'b10);
    assign store_wr   = cmd.access && wr_taken && (mode_reg == peeu_pkg::MODE_WRITE_EN);
    assign hit_a      = (eff_addr == peeu_pkg::UNLOCK_ADDR_A);
    assign hit_b      = (eff_addr == peeu_pkg::UNLOCK_ADDR_B);
    assign slot       = red_reg[SLOT_W-1:0];

    // product id byte for the raw address
    always_comb
    begin
        if (addr_reg == peeu_pkg::ID_ADDR_MFR)
            id_byte = peeu_pkg::ID_MFR;
        else if (addr_reg == peeu_pkg::ID_ADDR_DEV)
            id_byte = peeu_pkg::ID_DEV;
        else
            id_byte = 8'h00;
    end

    // capture and slot reduction by compare and subtract
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= peeu_pkg::op_t'(opcode);
            addr_reg <= bus_address;
            data_reg <= write_value[15:0];
            red_reg  <= bus_address[18:2];
            div_reg  <= DIV_INIT;
        end
        else if (cmd.reduce)
        begin
            if (red_reg >= div_reg)
                red_reg <= red_reg - div_reg;
            div_reg <= div_reg >> 1;
        end
    end

    // store port mux: clearing pass or transaction write
    assign mem_we    = cmd.clear_step || store_wr;
    assign mem_waddr = cmd.clear_step ? clr_cnt_reg : slot;
    assign mem_wdata = cmd.clear_step ? peeu_pkg::ERASED_BYTE : data_reg[7:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.access)
            rd_data_reg <= mem[slot];
    end

    // read-side flags latched with the store read
    always_ff @(posedge clk)
    begin
        if (cmd.access)
        begin
            pid_reg <= (mode_reg == peeu_pkg::MODE_PROD_ID);
            id_reg  <= id_byte;
        end
    end

    // command mode and unlock phase update
    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        if (cmd.access)
        begin
            if (is_read)
            begin
                if (mode_reg == peeu_pkg::MODE_WRITE_EN)
                    mode_next = peeu_pkg::MODE_NONE;
            end
            else if (wr_taken && (mode_reg != peeu_pkg::MODE_WRITE_EN) &&
                     (hit_a || hit_b))
            begin
                case (phase_reg)
                    peeu_pkg::PH_ONE:
                    begin
                        phase_next = (hit_b && data_reg == peeu_pkg::UNLOCK_DATA_2)
                                     ? peeu_pkg::PH_TWO : peeu_pkg::PH_IDLE;
                    end
                    peeu_pkg::PH_TWO:
                    begin
                        if (hit_a)
                        begin
                            if (data_reg == peeu_pkg::CMD_PROD_ID)
                                mode_next = peeu_pkg::MODE_PROD_ID;
                            else if (data_reg == peeu_pkg::CMD_WRITE_EN)
                                mode_next = peeu_pkg::MODE_WRITE_EN;
                            else
                                mode_next = peeu_pkg::MODE_NONE;
                        end
                        phase_next = peeu_pkg::PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = (hit_a && data_reg == peeu_pkg::UNLOCK_DATA_1)
                                     ? peeu_pkg::PH_ONE : peeu_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // result formatting for long and word reads
    assign res_byte = pid_reg ? id_reg : rd_data_reg;
    always_comb
    begin
        if (op_reg == peeu_pkg::OP_READ_LONG)
            res_value = {8'h00, res_byte, 16'h0000};
        else if (addr_reg[1:0] == 2'b00)
            res_value = {24'h000000, res_byte};
        else
            res_value = 32'h0000_0000;
    end

    // control registers, clear counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= peeu_pkg::MODE_NONE;
            phase_reg     <= peeu_pkg::PH_IDLE;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= res_value;
    end

    assign status.clear_done = (clr_cnt_reg == SLOT_W'(STORE_DEPTH - 1));
    assign status.is_read    = is_read;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign read_value = out_data_reg;

endmodule

`default_nettype wire

// ===== dv/parallel_eeprom_command_unlock_tb.sv =====
// ============================================================================
// parallel_eeprom_command_unlock_tb
// Self-checking bench for the command-unlocked cartridge EEPROM. A directed
// table covers reset contents, address extremes, product id and the unlock
// corner cases, then random unlock sequences, stores, reads and bus noise
// run against a cycle-free shadow of the store, mode and unlock phase.
// ============================================================================
`timescale 1ns / 1ps

module parallel_eeprom_command_unlock_tb;

    localparam int STORE_DEPTH    = 131072;
    localparam int ITEM_TARGET    = 750;
    localparam int HOLD_AT        = 250;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_AT       = 500;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 4 * STORE_DEPTH + 5000;
    localparam int PRINT_LIMIT    = 30;

    localparam logic [23:0] UNLOCK_A  = 24'h815554;
    localparam logic [23:0] UNLOCK_B  = 24'h80AAA8;
    localparam logic [23:0] ID_MFR_AT = 24'h800000;
    localparam logic [23:0] ID_DEV_AT = 24'h800004;
    localparam logic [23:0] LONG_ALIGN = 24'hFFFFFC;
    localparam logic [23:0] SLOT_BITS  = 24'h07FFFC;
    localparam logic [7:0]  MFR_CODE  = 8'h1F;
    localparam logic [7:0]  DEV_CODE  = 8'hD5;
    localparam logic [15:0] KEY_1     = 16'h00AA;
    localparam logic [15:0] KEY_2     = 16'h0055;
    localparam logic [15:0] CMD_ID    = 16'h0090;
    localparam logic [15:0] CMD_WE    = 16'h00A0;
    localparam logic [15:0] CMD_EXIT  = 16'h00F0;

    // one row of the directed table
    typedef struct packed {
        peeu_pkg::op_t op;
        logic [23:0]   addr;
        logic [31:0]   data;
        logic          typed;
        logic [31:0]   want;
    } access_row_t;

    localparam int DIRECTED_ROWS = 26;

    access_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        // erased contents after reset, offsets and address extremes
        '{peeu_pkg::OP_READ_LONG,  24'h000000, 32'h00000000, 1'b1, 32'h00FF0000},
        '{peeu_pkg::OP_READ_WORD,  24'h000000, 32'h00000000, 1'b1, 32'h000000FF},
        '{peeu_pkg::OP_READ_WORD,  24'h000002, 32'h00000000, 1'b1, 32'h00000000},
        '{peeu_pkg::OP_READ_LONG,  24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h00FF0000},
        // unlock into product id, upper data half ignored
        '{peeu_pkg::OP_WRITE_WORD, 24'h815554, 32'hFFFF00AA, 1'b0, 32'h0},
        '{peeu_pkg::OP_WRITE_WORD, 24'h80AAA8, 32'h00000055, 1'b0, 32'h0},
        '{peeu_pkg::OP_WRITE_WORD, 24'h815554, 32'h00000090, 1'b0, 32'h0},
        '{peeu_pkg::OP_READ_LONG,  24'h800000, 32'h00000000, 1'b1, 32'h001F0000},
        '{peeu_pkg::OP_READ_WORD,  24'h800004, 32'h00000000, 1'b1, 32'h000000D5},
        '{peeu_pkg::OP_READ_LONG,  24'h800008, 32'h00000000, 1'b1, 32'h00000000},
        '{peeu_pkg::OP_READ_WORD,  24'h800002, 32'h00000000, 1'b1, 32'h00000000},
        // exit command through a long write at an unaligned address
        '{peeu_pkg::OP_WRITE_WORD, 24'h815554, 32'h000000AA, 1'b0, 32'h0},
        '{peeu_pkg::OP_WRITE_WORD, 24'h80AAA8, 32'h00000055, 1'b0, 32'h0},
        '{peeu_pkg::OP_WRITE_LONG, 24'h815557, 32'hABCD00F0, 1'b0, 32'h0},
        '{peeu_pkg::OP_READ_LONG,  24'h800000, 32'h00000000, 1'b1, 32'h00FF0000},
        // write enable via long writes
        '{peeu_pkg::OP_WRITE_LONG, 24'h815556, 32'h123400AA, 1'b0, 32'h0},
        '{peeu_pkg::OP_WRITE_LONG, 24'h80AAA9, 32'hFFFF0055, 1'b0, 32'h0},
        '{peeu_pkg::OP_WRITE_WORD, 24'h815554, 32'h000000A0, 1'b0, 32'h0},
        '{peeu_pkg::OP_WRITE_WORD, 24'h000002, 32'h0000005A, 1'b0, 32'h0},
        '{peeu_pkg::OP_WRITE_LONG, 24'hFFFFFE, 32'hFFFFFF00, 1'b0, 32'h0},
        '{peeu_pkg::OP_WRITE_WORD, 24'h815554, 32'h000000AA, 1'b0, 32'h0},
        '{peeu_pkg::OP_READ_LONG,  24'h07FFFC, 32'h00000000, 1'b1, 32'h00000000},
        '{peeu_pkg::OP_READ_WORD,  24'h015554, 32'h00000000, 1'b0, 32'h0},
        // wrong second key drops back to idle
        '{peeu_pkg::OP_WRITE_WORD, 24'h815554, 32'h000000AA, 1'b0, 32'h0},
        '{peeu_pkg::OP_WRITE_WORD, 24'h80AAA8, 32'h00000155, 1'b0, 32'h0},
        '{peeu_pkg::OP_READ_WORD,  24'h000000, 32'h00000000, 1'b1, 32'h000000FF}
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic [1:0]  opcode      = 2'd0;
    logic [23:0] bus_address = 24'd0;
    logic [31:0] write_value = 32'd0;
    logic        out_ready   = 1'b0;
    wire         in_ready;
    wire         out_valid;
    wire  [31:0] read_value;

    // shadow of the device state
    logic [7:0]        shadow_store [0:STORE_DEPTH-1];
    peeu_pkg::mode_t   shadow_mode;
    peeu_pkg::phase_t  shadow_phase;

    logic [31:0] pending_reads [$];

    int  items_sent     = 0;
    int  reads_checked  = 0;
    int  mismatches     = 0;
    int  enabled_stores = 0;
    int  id_hits        = 0;
    int  commands_taken = 0;
    bit  steady_stretch = 1'b0;
    bit  sink_hold_done = 1'b0;
    bit  drain_done     = 1'b0;

    parallel_eeprom_command_unlock #(
        .STORE_DEPTH (STORE_DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .bus_address (bus_address),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------

    function automatic int unsigned slot_index(input logic [23:0] a);
        return ((a & SLOT_BITS) >> 2) % STORE_DEPTH;
    endfunction

    // read sees store or id codes, then drops write enable
    function automatic logic [31:0] shadow_read(input logic [23:0] a);
        logic [7:0] b;
        b = 8'h00;
        if (shadow_mode == peeu_pkg::MODE_PROD_ID)
        begin
            if (a == ID_MFR_AT)
            begin
                b = MFR_CODE;
                id_hits++;
            end
            else if (a == ID_DEV_AT)
            begin
                b = DEV_CODE;
                id_hits++;
            end
        end
        else
        begin
            b = shadow_store[slot_index(a)];
        end
        if (shadow_mode == peeu_pkg::MODE_WRITE_EN)
            shadow_mode = peeu_pkg::MODE_NONE;
        return {8'h00, b, 16'h0000};
    endfunction

    // word write: store under write enable, else advance the unlock phase
    function automatic void shadow_write(input logic [23:0] a, input logic [15:0] d);
        bit at_a;
        bit at_b;
        at_a = (a == UNLOCK_A);
        at_b = (a == UNLOCK_B);
        if (a[1:0] == 2'd2)
            return;
        if (shadow_mode == peeu_pkg::MODE_WRITE_EN)
        begin
            shadow_store[slot_index(a)] = d[7:0];
            enabled_stores++;
            return;
        end
        if (!at_a && !at_b)
            return;
        case (shadow_phase)
            peeu_pkg::PH_ONE:
            begin
                shadow_phase = (at_b && d == KEY_2) ? peeu_pkg::PH_TWO : peeu_pkg::PH_IDLE;
            end
            peeu_pkg::PH_TWO:
            begin
                if (at_a)
                begin
                    commands_taken++;
                    if (d == CMD_ID)
                        shadow_mode = peeu_pkg::MODE_PROD_ID;
                    else if (d == CMD_WE)
                        shadow_mode = peeu_pkg::MODE_WRITE_EN;
                    else
                        shadow_mode = peeu_pkg::MODE_NONE;
                end
                shadow_phase = peeu_pkg::PH_IDLE;
            end
            default:
            begin
                shadow_phase = (at_a && d == KEY_1) ? peeu_pkg::PH_ONE : peeu_pkg::PH_IDLE;
            end
        endcase
    endfunction

    function automatic bit predict_access(input peeu_pkg::op_t op, input logic [23:0] a,
                                          input logic [31:0] d, output logic [31:0] v);
        logic [31:0] raw;
        v = 32'h0;
        case (op)
            peeu_pkg::OP_READ_LONG:
            begin
                v = shadow_read(a);
                return 1'b1;
            end
            peeu_pkg::OP_READ_WORD:
            begin
                raw = shadow_read(a);
                v = (a[1:0] == 2'd0) ? {16'h0000, raw[31:16]} : {16'h0000, raw[15:0]};
                return 1'b1;
            end
            peeu_pkg::OP_WRITE_WORD:
            begin
                shadow_write(a, d[15:0]);
                return 1'b0;
            end
            default:
            begin
                shadow_write(a & LONG_ALIGN, d[15:0]);
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %08h, want %08h", $time, what, got, want);
    endtask

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (steady_stretch)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // addresses that mostly land on a small set of slots so reads hit stores
    function automatic logic [23:0] pool_address();
        logic [23:0] a;
        logic [16:0] slot;
        a = 24'($urandom());
        if ($urandom_range(0, 9) < 7)
        begin
            slot = 17'($urandom_range(0, 15));
            if ($urandom_range(0, 1) == 1)
                slot = ~slot;
            a[18:2] = slot;
        end
        return a;
    endfunction

    function automatic logic [15:0] pick_command();
        case ($urandom_range(0, 3))
            0: return CMD_ID;
            1: return CMD_WE;
            2: return CMD_EXIT;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic peeu_pkg::op_t pick_read_op();
        return ($urandom_range(0, 1) == 1) ? peeu_pkg::OP_READ_LONG : peeu_pkg::OP_READ_WORD;
    endfunction

    // offer one transaction, wait for it to be taken, record the outcome
    task automatic send_access(input peeu_pkg::op_t op, input logic [23:0] a,
                               input logic [31:0] d, input logic typed,
                               input logic [31:0] want);
        int          gap;
        logic [31:0] v;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        bus_address <= a;
        write_value <= d;
        do @(posedge clk); while (!in_ready);
        if (predict_access(op, a, d, v))
            pending_reads.push_back(typed ? want : v);
        items_sent++;
    endtask

    // unlock write as either a word write or a long write at a random low offset
    task automatic unlock_write(input logic [23:0] a, input logic [15:0] d);
        if ($urandom_range(0, 1) == 1)
            send_access(peeu_pkg::OP_WRITE_LONG, a | 24'($urandom_range(0, 3)),
                        {16'($urandom()), d}, 1'b0, 32'h0);
        else
            send_access(peeu_pkg::OP_WRITE_WORD, a, {16'($urandom()), d}, 1'b0, 32'h0);
    endtask

    task automatic unlock_command(input logic [15:0] cmd);
        unlock_write(UNLOCK_A, KEY_1);
        unlock_write(UNLOCK_B, KEY_2);
        unlock_write(UNLOCK_A, cmd);
    endtask

    task automatic random_access();
        send_access(peeu_pkg::op_t'($urandom_range(0, 3)), 24'($urandom()), $urandom(),
                    1'b0, 32'h0);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int          i;
        int          k;
        int          n;
        int          r;
        logic [23:0] a;
        logic [15:0] d;

        for (i = 0; i < STORE_DEPTH; i++)
            shadow_store[i] = 8'hFF;
        shadow_mode  = peeu_pkg::MODE_NONE;
        shadow_phase = peeu_pkg::PH_IDLE;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (i = 0; i < DIRECTED_ROWS; i++)
            send_access(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                        directed_rows[i].typed, directed_rows[i].want);

        // random sequences
        while (items_sent < ITEM_TARGET)
        begin
            // one pause with nothing in flight
            if (items_sent >= DRAIN_AT && !drain_done)
            begin
                drain_done = 1'b1;
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_reads.size() != 0);
            end

            steady_stretch = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                // write enable, then a mix of stores and reads
                unlock_command(CMD_WE);
                n = $urandom_range(2, 8);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 99) < 65)
                        send_access(($urandom_range(0, 1) == 1) ? peeu_pkg::OP_WRITE_LONG
                                                               : peeu_pkg::OP_WRITE_WORD,
                                    pool_address(), $urandom(), 1'b0, 32'h0);
                    else
                        send_access(pick_read_op(), pool_address(), 32'($urandom()),
                                    1'b0, 32'h0);
                end
            end
            else if (r < 55)
            begin
                // product id reads, sometimes left by a command
                unlock_command(CMD_ID);
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 3))
                        0: a = ID_MFR_AT;
                        1: a = ID_DEV_AT;
                        2: a = ID_MFR_AT | 24'($urandom_range(0, 7));
                        default: a = pool_address();
                    endcase
                    send_access(pick_read_op(), a, 32'($urandom()), 1'b0, 32'h0);
                end
                if ($urandom_range(0, 1) == 1)
                    unlock_command(($urandom_range(0, 1) == 1) ? CMD_EXIT : pick_command());
            end
            else if (r < 75)
            begin
                // unlock sequence with occasional damage
                for (k = 0; k < 3; k++)
                begin
                    a = (k == 1) ? UNLOCK_B : UNLOCK_A;
                    d = (k == 0) ? KEY_1 : (k == 1) ? KEY_2 : pick_command();
                    case ($urandom_range(0, 11))
                        0: d = d ^ (16'd1 << $urandom_range(0, 15));
                        1: a = (a == UNLOCK_A) ? UNLOCK_B : UNLOCK_A;
                        2: a = a | 24'd2;
                        3: send_access(pick_read_op(), pool_address(), 32'($urandom()),
                                       1'b0, 32'h0);
                        default: ;
                    endcase
                    // word write at offset two is dropped by the device
                    if (a[1:0] == 2'd2)
                        send_access(peeu_pkg::OP_WRITE_WORD, a, {16'($urandom()), d},
                                    1'b0, 32'h0);
                    else
                        unlock_write(a, d);
                end
                n = $urandom_range(1, 2);
                for (i = 0; i < n; i++)
                    send_access(pick_read_op(), pool_address(), 32'($urandom()), 1'b0, 32'h0);
            end
            else
            begin
                // bus noise over the whole field ranges
                n = $urandom_range(1, 5);
                for (i = 0; i < n; i++)
                    random_access();
            end
        end

        // wind down
        steady_stretch = 1'b0;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_reads.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d bus accesses and %0d checked reads, %0d mismatches",
                 items_sent, reads_checked, mismatches);
        $display("unlock commands taken %0d, enabled stores %0d, product id hits %0d",
                 commands_taken, enabled_stores, id_hits);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stalls and one long hold-off
    // ------------------------------------------------------------------

    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!sink_hold_done && items_sent >= HOLD_AT)
            begin
                sink_hold_done = 1'b1;
                out_ready      <= 1'b0;
                hold_left      = LONG_HOLD;
            end
            else
            begin
                out_ready <= 1'b1;
                hold_left = pick_gap();
            end
        end
    end

    // compare each taken read transaction with the oldest prediction
    always @(posedge clk)
    begin : read_check
        logic [31:0] oldest;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reads.size() == 0)
            begin
                report_mismatch("unexpected read_value", read_value, 32'h0);
            end
            else
            begin
                oldest = pending_reads.pop_front();
                reads_checked++;
                if (read_value !== oldest)
                    report_mismatch("read_value", read_value, oldest);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles, %0d reads still due",
                         quiet_cycles, pending_reads.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
